>>> design/pysamp_pkg.sv
// package for the pitman-yor assignment sampler
// types, codes and sizing constants used by the sampler top level; no dependencies
package pysamp_pkg;

	localparam int KINDS_DEF    = 16;
	localparam int FEATURES_DEF = 256;
	localparam int COUNT_MAX    = 511;
	localparam int COUNT_W      = 9;

	typedef enum logic [1:0] {
		ACT_LOAD_LIK   = 2'd0,
		ACT_LOAD_ASGN  = 2'd1,
		ACT_RESAMPLE   = 2'd2,
		ACT_NONE       = 2'd3
	} action_t;

	typedef enum logic [0:0] {
		REG_ALPHA    = 1'b0,
		REG_DISCOUNT = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ASGN_RD,
		ST_ASGN_UPD,
		ST_RS_RD,
		ST_RS_DOWN,
		ST_DIV,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_SCAN_RD,
		ST_SCAN_ACC,
		ST_CMP,
		ST_COMMIT,
		ST_OUT
	} state_t;

endpackage

>>> design/pitman_yor_assignment_sampler_top.sv
// pitman-yor collapsed gibbs assignment sampler, top level
// depends on pysamp_pkg; holds the likelihood memory, counts and the shared datapath
// A request carries one action. Likelihood loads and the unused action go through COMMIT
// and OUT; assignment loads go through ASGN_RD and ASGN_UPD first; a resample of a feature
// never loaded goes from RS_RD straight to COMMIT. A resample uses a restoring divider
// (one load step, 18 quotient steps) for the empty-kind weight, then one shared 17x16
// multiplier and two 40-bit accumulators walk the kinds twice: once to build the total,
// reading and accumulating each kind, and once for the running sum, reading, accumulating
// and comparing each kind against draw times total from a 40x16 multiplier, until the pick
// is found or the last kind is reached. The likelihood memory has a single read port. One
// result per request; the block takes no request until the result of the last one is
// taken. No clearing pass is needed.
module pitman_yor_assignment_sampler_top #(
	parameter int KINDS    = pysamp_pkg::KINDS_DEF,
	parameter int FEATURES = pysamp_pkg::FEATURES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  feature_index,
	input  logic [3:0]  kind_index,
	input  logic [15:0] likelihood,
	input  logic [15:0] uniform_draw,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  new_kind,
	output logic        status
);

	localparam int KW   = $clog2(KINDS);
	localparam int FW   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int EW   = $clog2(KINDS + 1);
	localparam int DEPTH = FEATURES * KINDS;
	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = pysamp_pkg::COUNT_W;
	localparam int NUMW = 18;  // alpha + discount*used < 2^18 for kinds up to 64

	// config registers
	logic [15:0] alpha_q;
	logic [7:0]  discount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q    <= 16'd256;
			discount_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (pysamp_pkg::reg_index_t'(cfg_index))
				pysamp_pkg::REG_ALPHA:    alpha_q    <= cfg_wdata;
				pysamp_pkg::REG_DISCOUNT: discount_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// memories
	logic [15:0]   lik_mem  [DEPTH];
	logic [KW-1:0] kind_mem [FEATURES];
	logic [15:0]   lik_rd_q;
	logic [KW-1:0] kind_rd_q;

	// per-feature loaded flags and per-kind counts
	logic [FEATURES-1:0] loaded_q;
	logic [CW-1:0]       count_q [KINDS];
	logic [EW-1:0]       empty_q;

	// request registers
	pysamp_pkg::action_t act_q;
	logic [FW-1:0] feat_q;
	logic [KW-1:0] kind_q;
	logic [15:0]   draw_q;
	logic          in_range_q;

	pysamp_pkg::state_t state_q, state_d;

	// iteration and datapath registers
	logic [KW-1:0]   k_q;
	logic [4:0]      div_cnt_q;
	logic [NUMW-1:0] quo_q;
	logic [NUMW-1:0] rem_q;
	logic [39:0]     total_q;
	logic [39:0]     run_q;
	logic [KW-1:0]   pick_q;
	logic            found_q;
	logic [3:0]      res_kind_q;
	logic            res_status_q;

	// count at current kind and its weight
	logic [CW-1:0] cnt_k;
	logic [16:0]   weight;
	logic [39:0]   prod_d;
	logic [AW-1:0] rd_addr;
	logic [55:0]   lhs, rhs;
	logic [NUMW-1:0] rem_sh;
	logic [EW-1:0]   used;

	assign cnt_k   = count_q[k_q];
	assign weight  = (cnt_k != '0) ? 17'({cnt_k, 8'd0} - {9'd0, discount_q})
	                               : 17'(quo_q);
	// single shared multiplier: weight times likelihood
	assign prod_d  = 40'(weight) * 40'(lik_rd_q);
	assign rd_addr = AW'({feat_q, k_q});
	assign used    = EW'(KINDS) - empty_q;
	assign rem_sh  = {rem_q[NUMW-2:0], quo_q[NUMW-1]};
	// running sum scaled by 2^16 against draw times total
	assign lhs     = {run_q, 16'd0};
	assign rhs     = 56'(total_q) * 56'(draw_q);

	assign in_ready  = (state_q == pysamp_pkg::ST_IDLE);
	assign out_valid = (state_q == pysamp_pkg::ST_OUT);
	assign new_kind  = res_kind_q;
	assign status    = res_status_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pysamp_pkg::ST_IDLE:
				if (in_valid) begin
					unique case (pysamp_pkg::action_t'(action))
						pysamp_pkg::ACT_LOAD_ASGN: state_d = pysamp_pkg::ST_ASGN_RD;
						pysamp_pkg::ACT_RESAMPLE:  state_d = pysamp_pkg::ST_RS_RD;
						default:                   state_d = pysamp_pkg::ST_COMMIT;
					endcase
				end
			pysamp_pkg::ST_ASGN_RD:  state_d = pysamp_pkg::ST_ASGN_UPD;
			pysamp_pkg::ST_ASGN_UPD: state_d = pysamp_pkg::ST_COMMIT;
			pysamp_pkg::ST_RS_RD:
				state_d = (in_range_q && loaded_q[feat_q]) ? pysamp_pkg::ST_RS_DOWN
				                                           : pysamp_pkg::ST_COMMIT;
			pysamp_pkg::ST_RS_DOWN:  state_d = pysamp_pkg::ST_DIV;
			pysamp_pkg::ST_DIV:
				if (div_cnt_q == 5'(NUMW)) state_d = pysamp_pkg::ST_SUM_RD;
			pysamp_pkg::ST_SUM_RD:   state_d = pysamp_pkg::ST_SUM_ACC;
			pysamp_pkg::ST_SUM_ACC:
				state_d = (k_q == KW'(KINDS - 1)) ? pysamp_pkg::ST_SCAN_RD
				                                  : pysamp_pkg::ST_SUM_RD;
			pysamp_pkg::ST_SCAN_RD:  state_d = pysamp_pkg::ST_SCAN_ACC;
			pysamp_pkg::ST_SCAN_ACC: state_d = pysamp_pkg::ST_CMP;
			pysamp_pkg::ST_CMP:
				state_d = (lhs > rhs || k_q == KW'(KINDS - 1)) ? pysamp_pkg::ST_COMMIT
				                                               : pysamp_pkg::ST_SCAN_RD;
			pysamp_pkg::ST_COMMIT:   state_d = pysamp_pkg::ST_OUT;
			pysamp_pkg::ST_OUT:
				if (out_ready) state_d = pysamp_pkg::ST_IDLE;
			default:                 state_d = pysamp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pysamp_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (state_q == pysamp_pkg::ST_IDLE && in_valid
		    && pysamp_pkg::action_t'(action) == pysamp_pkg::ACT_LOAD_LIK
		    && 32'(feature_index) < 32'(FEATURES) && 32'(kind_index) < 32'(KINDS))
			lik_mem[AW'({FW'(feature_index), KW'(kind_index)})] <= likelihood;
		lik_rd_q <= lik_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == pysamp_pkg::ST_COMMIT && act_q != pysamp_pkg::ACT_LOAD_LIK
		    && act_q != pysamp_pkg::ACT_NONE && in_range_q && res_status_q == 1'b0)
			kind_mem[feat_q] <= (act_q == pysamp_pkg::ACT_RESAMPLE) ? pick_q : kind_q;
		kind_rd_q <= kind_mem[feat_q];
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			pysamp_pkg::ST_IDLE: begin
				act_q      <= pysamp_pkg::action_t'(action);
				feat_q     <= FW'(feature_index);
				kind_q     <= KW'(kind_index);
				draw_q     <= uniform_draw;
				// resample validity ignores kind_index range
				in_range_q <= 32'(feature_index) < 32'(FEATURES)
				              && (32'(kind_index) < 32'(KINDS)
				                  || pysamp_pkg::action_t'(action)
				                     == pysamp_pkg::ACT_RESAMPLE);
				res_kind_q   <= kind_index;
				res_status_q <= 1'b0;
				k_q        <= '0;
			end
			pysamp_pkg::ST_RS_RD: begin
				if (!(in_range_q && loaded_q[feat_q])) begin
					res_kind_q   <= 4'd0;
					res_status_q <= 1'b1;
				end
			end
			pysamp_pkg::ST_RS_DOWN: begin
				pick_q    <= kind_rd_q;
				found_q   <= 1'b0;
				div_cnt_q <= '0;
				rem_q     <= '0;
				total_q   <= '0;
				run_q     <= '0;
			end
			pysamp_pkg::ST_DIV: begin
				// numerator loaded on first step, then one quotient bit per cycle
				if (div_cnt_q == '0) begin
					quo_q <= NUMW'(alpha_q) + NUMW'(discount_q) * NUMW'(used);
					rem_q <= '0;
				end else if (empty_q == '0) begin
					quo_q <= '0;
				end else if (div_cnt_q <= 5'(NUMW)) begin
					if (rem_sh >= NUMW'(empty_q)) begin
						rem_q <= rem_sh - NUMW'(empty_q);
						quo_q <= {quo_q[NUMW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[NUMW-2:0], 1'b0};
					end
				end
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			pysamp_pkg::ST_SUM_RD: ;
			pysamp_pkg::ST_SUM_ACC: begin
				total_q <= total_q + prod_d;
				if (prod_d != '0)
					pick_q <= k_q;
				k_q <= (k_q == KW'(KINDS - 1)) ? '0 : k_q + KW'(1);
			end
			pysamp_pkg::ST_SCAN_RD: ;
			pysamp_pkg::ST_SCAN_ACC: begin
				run_q  <= run_q + prod_d;
			end
			pysamp_pkg::ST_CMP: begin
				if (lhs > rhs) begin
					pick_q  <= k_q;
					found_q <= 1'b1;
				end else begin
					k_q <= k_q + KW'(1);
				end
			end
			pysamp_pkg::ST_COMMIT: begin
				if (act_q == pysamp_pkg::ACT_RESAMPLE && res_status_q == 1'b0)
					res_kind_q <= 4'(pick_q);
			end
			default: ;
		endcase
	end

	// loaded flags, counts, empty count
	logic          do_down, do_up;
	logic [KW-1:0] down_k, up_k;
	logic [CW-1:0] count_d [KINDS];
	logic [EW-1:0] empty_d;

	always_comb begin
		do_down = 1'b0;
		do_up   = 1'b0;
		down_k  = kind_rd_q;
		up_k    = kind_q;
		if (state_q == pysamp_pkg::ST_ASGN_UPD && in_range_q) begin
			do_down = loaded_q[feat_q];
			do_up   = 1'b1;
		end else if (state_q == pysamp_pkg::ST_RS_DOWN) begin
			do_down = 1'b1;
		end else if (state_q == pysamp_pkg::ST_COMMIT && act_q == pysamp_pkg::ACT_RESAMPLE
		             && res_status_q == 1'b0) begin
			do_up = 1'b1;
			up_k  = found_q ? pick_q : pick_q;
		end
	end

	// leave the old kind first, then join the new one
	always_comb begin
		for (int i = 0; i < KINDS; i++) count_d[i] = count_q[i];
		empty_d = empty_q;
		if (do_down && count_d[down_k] != '0) begin
			count_d[down_k] = count_d[down_k] - CW'(1);
			if (count_d[down_k] == '0) empty_d = empty_d + EW'(1);
		end
		if (do_up) begin
			if (count_d[up_k] == '0 && empty_d != '0)
				empty_d = empty_d - EW'(1);
			if (count_d[up_k] != CW'(pysamp_pkg::COUNT_MAX))
				count_d[up_k] = count_d[up_k] + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			for (int i = 0; i < KINDS; i++) count_q[i] <= '0;
			empty_q <= EW'(KINDS);
		end else begin
			if (state_q == pysamp_pkg::ST_ASGN_UPD && in_range_q)
				loaded_q[feat_q] <= 1'b1;
			for (int i = 0; i < KINDS; i++) count_q[i] <= count_d[i];
			empty_q <= empty_d;
		end
	end

	// checks
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pysamp_pkg::ST_SUM_RD && $past(state_q) == pysamp_pkg::ST_DIV
		|-> $past(div_cnt_q) == 5'(NUMW))
		else $error("divider left early");
	a_empty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(empty_q) <= 32'(KINDS))
		else $error("empty count beyond kinds");
	a_bad_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> new_kind == 4'd0)
		else $error("failed resample with nonzero kind");
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while result pending");

endmodule
